/* sv/urd_pkg.sv */
package urd_pkg;

  // Width of each operand and result field on the stream ports.
  localparam int FIELD_W = 64;
  localparam int TDATA_W = 2 * FIELD_W;

  // Requests from the top level to the divider core.
  typedef struct packed {
    logic start;
    logic take;
  } urd_ctrl_t;

  // Core status seen by the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } urd_status_t;

endpackage

/* sv/urd_core.sv */
module urd_core
  import urd_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  urd_ctrl_t             ctrl,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output urd_status_t           status,
  output logic [DATA_WIDTH-1:0] remainder,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic                  divide_by_zero
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] shq_r, shq_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic                  dbz_r, dbz_nxt;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  // The dividend shifts out of shq_r at the top while quotient bits enter at
  // the bottom, so after the last step shq_r holds the quotient.
  assign shifted = {rem_r, shq_r[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    shq_nxt   = shq_r;
    den_nxt   = den_r;
    dbz_nxt   = dbz_r;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.start) begin
          den_nxt = divisor;
          rem_nxt = '0;
          cnt_nxt = CNT_W'(DATA_WIDTH);
          if (divisor == '0) begin
            dbz_nxt   = 1'b1;
            shq_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            dbz_nxt   = 1'b0;
            shq_nxt   = dividend;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        rem_nxt = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        shq_nxt = {shq_r[DATA_WIDTH-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctrl.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    shq_r <= shq_nxt;
    den_r <= den_nxt;
    dbz_r <= dbz_nxt;
  end

  assign status.idle    = (state_r == ST_IDLE);
  assign status.done    = (state_r == ST_DONE);
  assign remainder      = rem_r;
  assign quotient       = shq_r;
  assign divide_by_zero = dbz_r;

endmodule

/* sv/unsigned_remainder_divider.sv */
// Unsigned divider returning remainder and quotient.
// Input channel: in_tdata carries dividend (bits 63:0) and divisor (bits 127:64);
// only the low DATA_WIDTH bits of each take part. Output channel: out_tdata
// carries remainder (63:0) and quotient (127:64), zero extended; out_tuser is
// the divide-by-zero flag, and with it set both results are zero.
// One quotient bit is resolved per cycle by a single restoring subtract step,
// with the core in its run state for the whole division. The core takes one
// request at a time: a new request is accepted only once the last result has
// left the core for the output register. A zero divisor skips the iteration;
// the core goes straight to its done state with both results zero.
// The result sits in an output register, so the core takes the next request
// while an earlier result still waits there. When the receiver stalls, a
// finished result is held in the core until the register frees, and in_tready
// stays low meanwhile. Synchronous reset drops any request in flight and
// empties the output register; no other state is kept between requests.
module unsigned_remainder_divider
  import urd_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // dividend [63:0], divisor [127:64]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // remainder [63:0], quotient [127:64]
  output logic               out_tuser   // divide_by_zero
);

  urd_ctrl_t             ctrl;
  urd_status_t           status;
  logic [DATA_WIDTH-1:0] core_rem;
  logic [DATA_WIDTH-1:0] core_quo;
  logic                  core_dbz;

  logic                  out_valid_r, out_valid_nxt;
  logic [TDATA_W-1:0]    out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  assign in_tready  = status.idle;
  assign ctrl.start = in_tvalid & status.idle;
  assign ctrl.take  = status.done & (~out_valid_r | out_tready);

  urd_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .dividend      (in_tdata[DATA_WIDTH-1:0]),
    .divisor       (in_tdata[FIELD_W +: DATA_WIDTH]),
    .status        (status),
    .remainder     (core_rem),
    .quotient      (core_quo),
    .divide_by_zero(core_dbz)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (ctrl.take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {FIELD_W'(core_quo), FIELD_W'(core_rem)};
      out_user_nxt  = core_dbz;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* sv/urd_checker.sv */
module urd_checker
  import urd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [TDATA_W-1:0] in_tdata,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tuser
);

  // A result offered to a stalled receiver stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  // A divide-by-zero result carries zero remainder and quotient.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("divide-by-zero result is not zero");

  // The core works on one request at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while the core is busy");

  // No result can appear right after a request whose divisor is nonzero,
  // unless one was already waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[TDATA_W-1:FIELD_W] != '0 && !out_tvalid
      |=> !out_tvalid)
    else $error("result appeared before the division finished");

endmodule

bind unsigned_remainder_divider urd_checker u_urd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import urd_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 534;

  typedef struct packed {
    logic [FIELD_W-1:0] remainder;
    logic [FIELD_W-1:0] quotient;
    logic               divide_by_zero;
  } division_result_t;

  class division_scoreboard;
    division_result_t pending[$];
    int fail_count;

    function new();
      fail_count = 0;
    endfunction

    // Restoring shift-subtract, one quotient bit per step from the top down.
    function division_result_t predict_division(logic [FIELD_W-1:0] dividend,
                                                logic [FIELD_W-1:0] divisor);
      division_result_t res;
      logic [FIELD_W:0] partial;
      res = '0;
      if (divisor == '0) begin
        res.divide_by_zero = 1'b1;
        return res;
      end
      partial = '0;
      for (int b = FIELD_W - 1; b >= 0; b--) begin
        partial = {partial[FIELD_W-1:0], dividend[b]};
        if (partial >= {1'b0, divisor}) begin
          partial = partial - {1'b0, divisor};
          res.quotient[b] = 1'b1;
        end
      end
      res.remainder = partial[FIELD_W-1:0];
      return res;
    endfunction

    function void note_request(logic [FIELD_W-1:0] dividend, logic [FIELD_W-1:0] divisor);
      pending.push_back(predict_division(dividend, divisor));
    endfunction

    function void check_result(logic [FIELD_W-1:0] remainder, logic [FIELD_W-1:0] quotient,
                               logic divide_by_zero);
      division_result_t exp_res;
      if (pending.size() == 0) begin
        $error("result arrived with no request pending");
        fail_count++;
        return;
      end
      exp_res = pending.pop_front();
      if (remainder !== exp_res.remainder) begin
        $error("remainder mismatch: expected %h, actual %h", exp_res.remainder, remainder);
        fail_count++;
      end
      if (quotient !== exp_res.quotient) begin
        $error("quotient mismatch: expected %h, actual %h", exp_res.quotient, quotient);
        fail_count++;
      end
      if (divide_by_zero !== exp_res.divide_by_zero) begin
        $error("divide_by_zero mismatch: expected %b, actual %b",
               exp_res.divide_by_zero, divide_by_zero);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  int send_idle_pct = 26;
  int recv_idle_pct = 83;
  int cycle_count = 0;

  division_scoreboard sb = new();

  unsigned_remainder_divider i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: ready is chosen at the falling edge, results are taken at the rising edge.
  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result(out_tdata[FIELD_W-1:0], out_tdata[TDATA_W-1:FIELD_W], out_tuser);
    end
  end

  function automatic logic [FIELD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is accepted.
  task automatic send_division(logic [FIELD_W-1:0] dividend, logic [FIELD_W-1:0] divisor);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {rand_word(), rand_word()};
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    do @(posedge clk); while (!in_tready);
    sb.note_request(dividend, divisor);
    @(negedge clk);
  endtask

  task automatic send_random_division();
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
    dividend = rand_word();
    divisor  = rand_word();
    case ($urandom_range(9))
      0: divisor = '0;
      1: divisor = FIELD_W'($urandom_range(255, 1));
      2: divisor[FIELD_W-1] = 1'b1;
      3: begin
        // Narrow operands of random widths reach short quotients and small divisors.
        dividend = dividend >> $urandom_range(FIELD_W - 1);
        divisor  = divisor >> $urandom_range(FIELD_W - 1);
      end
      4: if (dividend > divisor) dividend = divisor - 1;
      default: ;
    endcase
    send_division(dividend, divisor);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests: operand extremes, zero divisor and the top-bit carry case.
    send_division('0, '0);
    send_division('1, '0);
    send_division(64'h8000_0000_0000_0000, '0);
    send_division('0, 64'd1);
    send_division('1, 64'd1);
    send_division('1, '1);
    send_division('1 - 64'd1, '1);
    send_division(64'd1, '1);
    send_division('0, '1);
    send_division('1, 64'h8000_0000_0000_0000);
    send_division('1, 64'h8000_0000_0000_0001);
    send_division(64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001);
    send_division('1, 64'd2);
    send_division('1, 64'd3);
    send_division(64'h8000_0000_0000_0000, 64'd7);
    send_division(64'd100, 64'd7);
    send_division(64'd6, 64'd7);
    send_division(64'd7, 64'd7);
    send_division(64'h0123_4567_89AB_CDEF, 64'h0000_0001_0000_0000);
    send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_random_division();
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (FIELD_W + 8) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
